@@ rtl/utc_ld_pkg.sv @@
// Shared types, calendar constants and month-length lookup for the UTC-to-local date shifter.
`default_nettype none

package utc_ld_pkg;

   typedef logic [13:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  day_type;
   typedef logic [2:0]  weekday_type;
   typedef logic [4:0]  hour_type;
   typedef logic [5:0]  minute_type;
   typedef logic [5:0]  second_type;
   typedef logic signed [4:0] offset_type;

   localparam year_type    YearMax      = 14'd9999;
   localparam month_type   MonthFirst   = 4'd1;
   localparam month_type   MonthLast    = 4'd12;
   localparam day_type     DayFirst     = 5'd1;
   localparam weekday_type WeekdayLast  = 3'd6;
   localparam logic [6:0]  HoursPerDay  = 7'd24;

   // floor(y / 25) == (y * Div25Mult) >> Div25Shift for y <= 9999
   localparam logic [12:0] Div25Mult    = 13'd5243;
   localparam int          Div25Shift   = 17;

   function automatic day_type month_len(input month_type month, input logic leap);
      day_type len;
      unique case (month)
         4'd2:                       len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
         default:                    len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ rtl/utc_to_local_date_shift.sv @@
// Top level: applies a whole-hour zone offset to a UTC calendar time, with date carry.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  utc year, month, day, weekday, hour, min, sec
//   rsp_     out        rsp_valid / rsp_stall  local year, month, day, weekday, hour, min, sec
//   csr_     in         csr_wr_en              zone offset in hours, 5-bit signed
//
// One item per cycle sustained while rsp_stall is low; items pass an input register, then a result register.
// The leap-year test, clamps and carry sit in one combinational pass between the two.
// Reset clears both valid flags and sets the offset to zero.
// rsp_stall holds the result register; the input register keeps taking an item
// while the result register is full and only stalls req_ when both are occupied.
`default_nettype none

module utc_to_local_date_shift (
   input  wire                         clock,
   input  wire                         reset,

   input  wire                         req_valid,
   output logic                        req_stall,
   input  utc_ld_pkg::year_type        req_utc_year,
   input  utc_ld_pkg::month_type       req_utc_month,
   input  utc_ld_pkg::day_type         req_utc_day,
   input  utc_ld_pkg::weekday_type     req_utc_weekday,
   input  utc_ld_pkg::hour_type        req_utc_hour,
   input  utc_ld_pkg::minute_type      req_utc_minute,
   input  utc_ld_pkg::second_type      req_utc_second,

   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output utc_ld_pkg::year_type        rsp_local_year,
   output utc_ld_pkg::month_type       rsp_local_month,
   output utc_ld_pkg::day_type         rsp_local_day,
   output utc_ld_pkg::weekday_type     rsp_local_weekday,
   output utc_ld_pkg::hour_type        rsp_local_hour,
   output utc_ld_pkg::minute_type      rsp_local_minute,
   output utc_ld_pkg::second_type      rsp_local_second,

   input  wire                         csr_wr_en,
   input  utc_ld_pkg::offset_type      csr_wr_data
);

   import utc_ld_pkg::*;

   offset_type  offset_ff;

   logic        s1_valid_ff;
   year_type    s1_year_ff;
   month_type   s1_month_ff;
   day_type     s1_day_ff;
   weekday_type s1_wday_ff;
   hour_type    s1_hour_ff;
   minute_type  s1_minute_ff;
   second_type  s1_second_ff;

   logic        rsp_valid_ff;
   year_type    rsp_year_ff;
   month_type   rsp_month_ff;
   day_type     rsp_day_ff;
   weekday_type rsp_wday_ff;
   hour_type    rsp_hour_ff;
   minute_type  rsp_minute_ff;
   second_type  rsp_second_ff;

   year_type    rsp_year_in;
   month_type   rsp_month_in;
   day_type     rsp_day_in;
   weekday_type rsp_wday_in;
   hour_type    rsp_hour_in;

   logic        advance;
   logic        s1_load;

   year_type    year_c;
   month_type   month_c;
   day_type     day_c;
   weekday_type wday_c;
   day_type     len_c;
   logic [26:0] div25_prod;
   logic [9:0]  div25_quot;
   logic        div25;
   logic        leap;
   logic [6:0]  hour_sum;
   logic        step_back;
   logic        step_fwd;
   month_type   prev_month;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || advance;
   assign req_stall = s1_valid_ff && !advance;

   // offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_year_ff   <= req_utc_year;
         s1_month_ff  <= req_utc_month;
         s1_day_ff    <= req_utc_day;
         s1_wday_ff   <= req_utc_weekday;
         s1_hour_ff   <= req_utc_hour;
         s1_minute_ff <= req_utc_minute;
         s1_second_ff <= req_utc_second;
      end
   end

   // clamp the fields into range
   always_comb begin
      year_c = (s1_year_ff > YearMax) ? YearMax : s1_year_ff;

      if (s1_month_ff < MonthFirst) begin
         month_c = MonthFirst;
      end else if (s1_month_ff > MonthLast) begin
         month_c = MonthLast;
      end else begin
         month_c = s1_month_ff;
      end

      div25_prod = 27'(year_c) * 27'(Div25Mult);
      div25_quot = div25_prod[26:Div25Shift];
      div25      = (year_c == 14'(14'(div25_quot) * 14'd25));
      leap       = (year_c[1:0] == 2'b00) && (!div25 || (year_c[3:0] == 4'b0000));

      len_c = month_len(month_c, leap);

      if (s1_day_ff < DayFirst) begin
         day_c = DayFirst;
      end else if (s1_day_ff > len_c) begin
         day_c = len_c;
      end else begin
         day_c = s1_day_ff;
      end

      wday_c = (s1_wday_ff > WeekdayLast) ? '0 : s1_wday_ff;
   end

   // hour shift and one-day carry
   always_comb begin
      hour_sum   = {2'b00, s1_hour_ff} + {{2{offset_ff[4]}}, offset_ff};
      step_back  = hour_sum[6];
      step_fwd   = !hour_sum[6] && (hour_sum >= HoursPerDay);
      prev_month = month_c - 4'd1;

      rsp_year_in  = year_c;
      rsp_month_in = month_c;
      rsp_day_in   = day_c;
      rsp_wday_in  = wday_c;
      rsp_hour_in  = hour_sum[4:0];

      if (step_back) begin
         rsp_hour_in = 5'(hour_sum + HoursPerDay);
         rsp_wday_in = (wday_c == '0) ? WeekdayLast : wday_c - 3'd1;
         if (day_c > DayFirst) begin
            rsp_day_in = day_c - 5'd1;
         end else if (month_c > MonthFirst) begin
            rsp_month_in = prev_month;
            rsp_day_in   = month_len(prev_month, leap);
         end else begin
            rsp_month_in = MonthLast;
            rsp_day_in   = month_len(MonthLast, 1'b0);
            rsp_year_in  = (year_c != '0) ? year_c - 14'd1 : year_c;
         end
      end else if (step_fwd) begin
         rsp_hour_in = 5'(hour_sum - HoursPerDay);
         rsp_wday_in = (wday_c == WeekdayLast) ? '0 : wday_c + 3'd1;
         if (day_c < len_c) begin
            rsp_day_in = day_c + 5'd1;
         end else begin
            rsp_day_in = DayFirst;
            if (month_c < MonthLast) begin
               rsp_month_in = month_c + 4'd1;
            end else begin
               rsp_month_in = MonthFirst;
               rsp_year_in  = (year_c < YearMax) ? year_c + 14'd1 : year_c;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_year_ff   <= rsp_year_in;
         rsp_month_ff  <= rsp_month_in;
         rsp_day_ff    <= rsp_day_in;
         rsp_wday_ff   <= rsp_wday_in;
         rsp_hour_ff   <= rsp_hour_in;
         rsp_minute_ff <= s1_minute_ff;
         rsp_second_ff <= s1_second_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_local_year    = rsp_year_ff;
   assign rsp_local_month   = rsp_month_ff;
   assign rsp_local_day     = rsp_day_ff;
   assign rsp_local_weekday = rsp_wday_ff;
   assign rsp_local_hour    = rsp_hour_ff;
   assign rsp_local_minute  = rsp_minute_ff;
   assign rsp_local_second  = rsp_second_ff;

   a_hour_in_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hour_ff < 5'd24))
      else $error("local hour out of range");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_month_ff >= MonthFirst) && (rsp_month_ff <= MonthLast)
                    && (rsp_day_ff >= DayFirst) && (rsp_wday_ff <= WeekdayLast)
                    && (rsp_year_ff <= YearMax))
      else $error("local date out of range");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_year_ff) && $stable(s1_hour_ff))
      else $error("held item lost from input register");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_day_ff))
      else $error("stalled item changed");

endmodule

`default_nettype wire

@@ dv/tb_utc_to_local_date_shift.sv @@
// Testbench for the UTC-to-local date shifter: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_utc_to_local_date_shift;
   import utc_ld_pkg::*;

   localparam int CycleLimit    = 200000;
   localparam int HoldoffCycles = 60;
   localparam int DrainCycles   = 8;

   typedef struct packed {
      year_type    year;
      month_type   month;
      day_type     day;
      weekday_type weekday;
      hour_type    hour;
      minute_type  minute;
      second_type  second;
   } cal_time_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   year_type    req_utc_year;
   month_type   req_utc_month;
   day_type     req_utc_day;
   weekday_type req_utc_weekday;
   hour_type    req_utc_hour;
   minute_type  req_utc_minute;
   second_type  req_utc_second;
   logic        rsp_valid;
   logic        rsp_stall;
   year_type    rsp_local_year;
   month_type   rsp_local_month;
   day_type     rsp_local_day;
   weekday_type rsp_local_weekday;
   hour_type    rsp_local_hour;
   minute_type  rsp_local_minute;
   second_type  rsp_local_second;
   logic        csr_wr_en;
   offset_type  csr_wr_data;

   cal_time_type expected_local[$];
   offset_type   zone_offset;
   int           error_count;
   int           cycle_count;
   int           send_idle_pct;
   int           rsp_stall_pct;
   logic         holding;
   event         start_holdoff;
   int           notable_years[10] = '{0, 1, 99, 100, 399, 400, 1900, 2000, 9998, 9999};

   utc_to_local_date_shift i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_utc_year      (req_utc_year),
      .req_utc_month     (req_utc_month),
      .req_utc_day       (req_utc_day),
      .req_utc_weekday   (req_utc_weekday),
      .req_utc_hour      (req_utc_hour),
      .req_utc_minute    (req_utc_minute),
      .req_utc_second    (req_utc_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_local_year    (rsp_local_year),
      .rsp_local_month   (rsp_local_month),
      .rsp_local_day     (rsp_local_day),
      .rsp_local_weekday (rsp_local_weekday),
      .rsp_local_hour    (rsp_local_hour),
      .rsp_local_minute  (rsp_local_minute),
      .rsp_local_second  (rsp_local_second),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int days_in_month(input int y, input int m);
      bit leap;
      leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      case (m)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic cal_time_type shift_to_local(input cal_time_type t, input offset_type off);
      int y, m, d, w, h, len;
      cal_time_type r;
      y = t.year;
      m = t.month;
      d = t.day;
      w = t.weekday;
      h = t.hour;
      // clamp out-of-range fields first
      if (y > YearMax) y = YearMax;
      if (m < MonthFirst) m = MonthFirst;
      if (m > MonthLast) m = MonthLast;
      len = days_in_month(y, m);
      if (d < 1) d = 1;
      if (d > len) d = len;
      if (w >= 7) w -= 7;
      h = h + int'(off);
      if (h < 0) begin
         w = (w == 0) ? 6 : w - 1;
         if (d > 1) begin
            d--;
         end else begin
            if (m > 1) begin
               m--;
            end else begin
               m = 12;
               if (y > 0) y--;
            end
            d = days_in_month(y, m);
         end
         h += 24;
      end else if (h >= 24) begin
         w = (w + 1 >= 7) ? 0 : w + 1;
         if (d < len) begin
            d++;
         end else begin
            d = 1;
            if (m < 12) begin
               m++;
            end else begin
               m = 1;
               if (y < YearMax) y++;
            end
         end
         h -= 24;
      end
      r.year    = year_type'(y);
      r.month   = month_type'(m);
      r.day     = day_type'(d);
      r.weekday = weekday_type'(w);
      r.hour    = hour_type'(h);
      r.minute  = t.minute;
      r.second  = t.second;
      return r;
   endfunction

   function automatic cal_time_type random_utc_time();
      cal_time_type t;
      int len;
      // a tenth of items are raw bits, so every field sees its full encoding
      if ($urandom_range(9) == 0) begin
         t.year    = year_type'($urandom);
         t.month   = month_type'($urandom);
         t.day     = day_type'($urandom);
         t.weekday = weekday_type'($urandom);
         t.hour    = hour_type'($urandom);
         t.minute  = minute_type'($urandom);
         t.second  = second_type'($urandom);
         return t;
      end
      t.year    = year_type'(($urandom_range(3) == 0) ? notable_years[$urandom_range(9)]
                                                      : int'($urandom_range(9999)));
      t.month   = month_type'(($urandom_range(4) == 0) ? ($urandom_range(1) ? 12 : 1)
                                                       : int'($urandom_range(12, 1)));
      len       = days_in_month(t.year, t.month);
      t.day     = day_type'(($urandom_range(4) < 2) ? ($urandom_range(1) ? len : 1)
                                                    : int'($urandom_range(len, 1)));
      t.weekday = weekday_type'($urandom_range(6));
      t.hour    = hour_type'($urandom_range(23));
      t.minute  = minute_type'($urandom_range(59));
      t.second  = second_type'($urandom_range(59));
      return t;
   endfunction

   task automatic send_time(input cal_time_type t);
      req_valid       <= 1'b1;
      req_utc_year    <= t.year;
      req_utc_month   <= t.month;
      req_utc_day     <= t.day;
      req_utc_weekday <= t.weekday;
      req_utc_hour    <= t.hour;
      req_utc_minute  <= t.minute;
      req_utc_second  <= t.second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_local.push_back(shift_to_local(t, zone_offset));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_fields(input int y, input int m, input int d, input int w,
                              input int h, input int mi, input int s);
      cal_time_type t;
      t.year    = year_type'(y);
      t.month   = month_type'(m);
      t.day     = day_type'(d);
      t.weekday = weekday_type'(w);
      t.hour    = hour_type'(h);
      t.minute  = minute_type'(mi);
      t.second  = second_type'(s);
      send_time(t);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_local.size() != 0) @(posedge clock);
   endtask

   task automatic write_zone_offset(input offset_type off);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= off;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      zone_offset = off;
   endtask

   task automatic check_field(input string field_name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
         error_count++;
      end
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      cal_time_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_local.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                     $time, rsp_local_year, rsp_local_month, rsp_local_day,
                     rsp_local_hour, rsp_local_minute, rsp_local_second);
            error_count++;
         end else begin
            want = expected_local.pop_front();
            check_field("local_year",    want.year,    rsp_local_year);
            check_field("local_month",   want.month,   rsp_local_month);
            check_field("local_day",     want.day,     rsp_local_day);
            check_field("local_weekday", want.weekday, rsp_local_weekday);
            check_field("local_hour",    want.hour,    rsp_local_hour);
            check_field("local_minute",  want.minute,  rsp_local_minute);
            check_field("local_second",  want.second,  rsp_local_second);
         end
      end
      rsp_stall <= holding || ($urandom_range(99) < rsp_stall_pct);
   end

   // long receiver hold-off
   initial begin
      holding = 1'b0;
      forever begin
         @(start_holdoff);
         holding <= 1'b1;
         repeat (HoldoffCycles) @(posedge clock);
         holding <= 1'b0;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic test_reset_offset();
      send_fields(0, 1, 1, 0, 0, 0, 0);
      send_fields(9999, 12, 31, 6, 23, 59, 59);
      send_fields(2024, 2, 29, 4, 12, 30, 45);
      wait_all_results();
   endtask

   task automatic test_forward_rollover();
      write_zone_offset(offset_type'(14));
      send_fields(9999, 12, 31, 5, 23, 59, 59);   // year held at top
      send_fields(2023, 2, 28, 2, 10, 1, 2);
      send_fields(2024, 2, 28, 3, 10, 3, 4);
      send_fields(1900, 2, 28, 3, 12, 5, 6);
      send_fields(2000, 2, 28, 1, 20, 7, 8);
      send_fields(2023, 4, 30, 6, 15, 9, 10);
      send_fields(2023, 12, 31, 0, 9, 11, 12);
      wait_all_results();
      write_zone_offset(offset_type'(15));
      send_fields(2023, 6, 15, 6, 8, 13, 14);
      send_fields(2023, 6, 15, 6, 9, 15, 16);
      wait_all_results();
   endtask

   task automatic test_backward_rollover();
      write_zone_offset(offset_type'(-12));
      send_fields(0, 1, 1, 0, 0, 17, 18);         // year held at zero
      send_fields(2024, 3, 1, 5, 5, 19, 20);
      send_fields(2100, 3, 1, 1, 3, 21, 22);
      send_fields(2023, 5, 1, 1, 11, 23, 24);
      send_fields(2024, 1, 1, 1, 0, 25, 26);
      wait_all_results();
      write_zone_offset(offset_type'(-16));
      send_fields(2023, 7, 10, 3, 15, 27, 28);
      send_fields(2023, 7, 10, 3, 16, 29, 30);
      wait_all_results();
   endtask

   task automatic test_clamping();
      write_zone_offset(offset_type'(0));
      send_fields(16383, 15, 0, 7, 31, 63, 63);
      send_fields(10000, 0, 31, 7, 24, 60, 0);
      send_fields(2023, 2, 31, 3, 10, 0, 63);
      send_fields(2024, 4, 31, 2, 23, 42, 21);
      wait_all_results();
   endtask

   task automatic test_random_phases();
      int send_pct[4];
      int stall_pct[4];
      send_pct  = '{0, 49, 0, 10};
      stall_pct = '{0, 0, 49, 10};
      for (int p = 0; p < 4; p++) begin
         wait_all_results();
         case (p)
            0:       write_zone_offset(offset_type'(-12));
            1:       write_zone_offset(offset_type'(14));
            default: write_zone_offset(offset_type'($urandom_range(31)));
         endcase
         send_idle_pct = send_pct[p];
         rsp_stall_pct = stall_pct[p];
         repeat (200) send_time(random_utc_time());
      end
      wait_all_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> start_holdoff;
      repeat (24) send_time(random_utc_time());
      wait_all_results();
   endtask

   task automatic test_sender_pause();
      write_zone_offset(offset_type'($urandom_range(31)));
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      repeat (12) send_time(random_utc_time());
      wait_all_results();
      repeat (12) send_time(random_utc_time());
      wait_all_results();
   endtask

   initial begin
      error_count     = 0;
      zone_offset     = '0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_utc_year    = '0;
      req_utc_month   = '0;
      req_utc_day     = '0;
      req_utc_weekday = '0;
      req_utc_hour    = '0;
      req_utc_minute  = '0;
      req_utc_second  = '0;
      rsp_stall       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_offset();
      test_forward_rollover();
      test_backward_rollover();
      test_clamping();
      test_random_phases();
      test_backpressure();
      test_sender_pause();

      wait_all_results();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
